[hdl/bfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit field packer/unpacker package
// Command and status codes, field size constants and the command/status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfp_pkg;

  // Field size limits
  localparam int MAX_FIELD_BITS = 32;
  localparam int LEN_BITS       = 5;
  // Largest self-sized field: 5-bit length plus 31 value bits
  localparam int VAR_MAX_BITS   = 36;
  // Bytes one field can touch: 7 bits of offset plus VAR_MAX_BITS
  localparam int FIELD_BYTES    = 6;

  // Input item layout on s_tdata
  localparam int IN_TDATA_W     = 80;

  // Command codes
  localparam logic [3:0] CMD_WRITE     = 4'd0;
  localparam logic [3:0] CMD_READ      = 4'd1;
  localparam logic [3:0] CMD_WRITE_FOR = 4'd2;
  localparam logic [3:0] CMD_READ_FOR  = 4'd3;
  localparam logic [3:0] CMD_WRITE_VAR = 4'd4;
  localparam logic [3:0] CMD_READ_VAR  = 4'd5;
  localparam logic [3:0] CMD_ALIGN     = 4'd6;
  localparam logic [3:0] CMD_REWIND    = 4'd7;
  localparam logic [3:0] CMD_TO_END    = 4'd8;
  localparam logic [3:0] CMD_CLEAR     = 4'd9;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PAST_FILL = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Controller to datapath strobes
  typedef struct packed {
    logic load;     // latch the input item
    logic decode;   // register field widths
    logic check;    // register bounds check and write word
    logic rd_old;   // read the first byte for a merge
    logic wr;       // write one store byte
    logic rd;       // read one store byte
    logic extract;  // register the read field
    logic commit;   // update cursors and load the result item
  } bfp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic chk_err;    // field does not fit
    logic span_zero;  // field touches no byte
    logic is_write;
    logic is_read;
    logic bit_nz;     // cursor sits inside a byte
    logic cnt_last;   // byte counter on the last byte
  } bfp_stat_t;

endpackage

[hdl/bfp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/bfp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit field packer/unpacker controller
// Sequences decode, bounds check, byte reads and writes and result commit,
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module bfp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  bfp_pkg::bfp_stat_t stat,
  output bfp_pkg::bfp_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECODE  = 9'b000000010,
    S_CHECK   = 9'b000000100,
    S_RD_OLD  = 9'b000001000,
    S_WRITE   = 9'b000010000,
    S_READ    = 9'b000100000,
    S_DRAIN   = 9'b001000000,
    S_EXTRACT = 9'b010000000,
    S_FINISH  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  // Next state and strobes
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if ((!stat.is_write && !stat.is_read) || stat.chk_err || stat.span_zero) begin
          state_next = S_FINISH;
        end else if (stat.is_write) begin
          state_next = stat.bit_nz ? S_RD_OLD : S_WRITE;
        end else begin
          state_next = S_READ;
        end
      end
      S_RD_OLD: begin
        cmd.rd_old = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr = 1'b1;
        if (stat.cnt_last) begin
          state_next = S_FINISH;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        if (stat.cnt_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EXTRACT;
      end
      S_EXTRACT: begin
        cmd.extract = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold the result item until it is taken
  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

endmodule

[hdl/bfp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit field packer/unpacker datapath
// Field width decode, bounds checks, byte store, write word assembly,
// read window extraction, cursors and the result register.
// ----------------------------------------------------------------------------
module bfp_datapath #(
  parameter int STORE_BYTES = 1024,
  localparam int CW = $clog2(STORE_BYTES + 1),
  localparam int AW = $clog2(STORE_BYTES)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [3:0]         command,
  input  logic [31:0]        value,
  input  logic [5:0]         width,
  input  logic [31:0]        limit,
  input  bfp_pkg::bfp_cmd_t  cmd,
  output bfp_pkg::bfp_stat_t stat,
  output logic [31:0]        read_data,
  output logic [5:0]         width_used,
  output logic [1:0]         status,
  output logic [CW-1:0]      byte_position,
  output logic [2:0]         bit_position,
  output logic [CW-1:0]      filled_bytes
);

  localparam int WB = 8 * bfp_pkg::FIELD_BYTES;
  localparam logic [CW:0] STORE_LIM = (CW + 1)'(STORE_BYTES);

  // Smallest width 1..31 that holds x, zero when bit 31 is set
  function automatic logic [5:0] bits_for(input logic [31:0] x);
    logic [5:0] r;
    r = 6'd1;
    for (int i = 0; i < 31; i++) begin
      if (x[i]) r = 6'(i + 1);
    end
    if (x[31]) r = 6'd0;
    return r;
  endfunction

  function automatic logic [5:0] clamp_w(input logic [5:0] w);
    return (w > 6'(bfp_pkg::MAX_FIELD_BITS)) ? 6'(bfp_pkg::MAX_FIELD_BITS) : w;
  endfunction

  function automatic logic [31:0] low_mask(input logic [5:0] w);
    logic [32:0] m;
    m = (33'd1 << w) - 33'd1;
    return m[31:0];
  endfunction

  // Bytes touched by n bits starting at bit offset b
  function automatic logic [3:0] span_f(input logic [2:0] b, input logic [5:0] n);
    logic [6:0] s;
    s = 7'(b) + 7'(n) + 7'd7;
    return (n == 6'd0) ? 4'd0 : s[6:3];
  endfunction

  // Latched item
  logic [3:0]  cmd_q;
  logic [31:0] value_q;
  logic [5:0]  width_q;
  logic [31:0] limit_q;

  // Decoded widths
  logic [5:0]  fld_w, fld_tw;

  // Pending result
  logic [31:0] res_data;
  logic [5:0]  res_used;
  logic [1:0]  res_status;
  logic [5:0]  adv_bits;
  logic        fill_upd;
  logic [2:0]  nbytes_q;

  // Byte buffers and sequencing
  logic [bfp_pkg::FIELD_BYTES-1:0][7:0] word_q;
  logic [bfp_pkg::FIELD_BYTES-1:0][7:0] window;
  logic [2:0]  cnt;
  logic        cap_valid;
  logic [2:0]  cap_idx;

  // Cursors
  logic [CW-1:0] byte_cursor, fill_length;
  logic [2:0]    bit_cursor;

  // Command classes
  logic is_plain, is_for, is_wvar, is_rvar, is_write, is_read;
  assign is_plain = (cmd_q == bfp_pkg::CMD_WRITE) || (cmd_q == bfp_pkg::CMD_READ);
  assign is_for   = (cmd_q == bfp_pkg::CMD_WRITE_FOR) || (cmd_q == bfp_pkg::CMD_READ_FOR);
  assign is_wvar  = (cmd_q == bfp_pkg::CMD_WRITE_VAR);
  assign is_rvar  = (cmd_q == bfp_pkg::CMD_READ_VAR);
  assign is_write = (cmd_q == bfp_pkg::CMD_WRITE) || (cmd_q == bfp_pkg::CMD_WRITE_FOR) ||
                    is_wvar;
  assign is_read  = (cmd_q == bfp_pkg::CMD_READ) || (cmd_q == bfp_pkg::CMD_READ_FOR) ||
                    is_rvar;

  // Decode: field width and total bits
  logic [5:0] enc, dec_w, dec_tw;
  always_comb begin
    enc = bits_for(is_wvar ? value_q : limit_q);
    if (is_plain) begin
      dec_w = clamp_w(width_q);
    end else if (is_for || is_wvar) begin
      dec_w = clamp_w(enc);
    end else begin
      dec_w = 6'd0;
    end
    if (is_wvar) begin
      dec_tw = dec_w + 6'(bfp_pkg::LEN_BITS);
    end else if (is_rvar) begin
      dec_tw = 6'(bfp_pkg::LEN_BITS);
    end else begin
      dec_tw = dec_w;
    end
  end

  // Check: bounds, read byte count and write word
  logic [3:0]  chk_span;
  logic [CW:0] chk_sum;
  logic        chk_err;
  logic        over;
  logic [31:0] fld_val32;
  logic [36:0] fld_value;
  logic [WB-1:0] word_next;
  logic [2:0]  chk_nbytes;
  always_comb begin
    chk_span = span_f(bit_cursor, fld_tw);
    chk_sum  = (CW + 1)'(byte_cursor) + (CW + 1)'(chk_span);
    if (is_write) begin
      chk_err = chk_sum > STORE_LIM;
    end else if (is_read) begin
      chk_err = chk_sum > {1'b0, fill_length};
    end else begin
      chk_err = 1'b0;
    end
    over      = |(value_q >> fld_w);
    fld_val32 = over ? low_mask(fld_w) : value_q;
    if (is_wvar) begin
      fld_value = {fld_val32, fld_w[4:0]};
    end else begin
      fld_value = 37'(fld_val32);
    end
    word_next = WB'(fld_value) << bit_cursor;
    if (is_rvar) begin
      chk_nbytes = 3'(span_f(bit_cursor, 6'(bfp_pkg::VAR_MAX_BITS)));
    end else begin
      chk_nbytes = 3'(chk_span);
    end
  end

  // Extract: field from the read window
  logic [WB-1:0] win_sh;
  logic [4:0]    var_len;
  logic [5:0]    var_tw;
  logic [CW:0]   var_sum;
  logic          var_err;
  always_comb begin
    win_sh  = window >> bit_cursor;
    var_len = win_sh[4:0];
    var_tw  = 6'(var_len) + 6'(bfp_pkg::LEN_BITS);
    var_sum = (CW + 1)'(byte_cursor) + (CW + 1)'(span_f(bit_cursor, var_tw));
    var_err = var_sum > {1'b0, fill_length};
  end

  // Commit: next cursors
  logic [6:0]    adv_end;
  logic [CW:0]   fill_cand;
  logic [CW-1:0] byte_next, fill_next;
  logic [2:0]    bit_next;
  always_comb begin
    adv_end   = 7'(bit_cursor) + 7'(adv_bits);
    fill_cand = (CW + 1)'(byte_cursor) + (CW + 1)'(nbytes_q);
    byte_next = byte_cursor;
    bit_next  = bit_cursor;
    fill_next = fill_length;
    case (cmd_q)
      bfp_pkg::CMD_ALIGN: begin
        if (bit_cursor != 3'd0) begin
          byte_next = byte_cursor + CW'(1);
          bit_next  = 3'd0;
        end
      end
      bfp_pkg::CMD_REWIND: begin
        byte_next = '0;
        bit_next  = 3'd0;
      end
      bfp_pkg::CMD_TO_END: begin
        byte_next = fill_length;
        bit_next  = 3'd0;
      end
      bfp_pkg::CMD_CLEAR: begin
        byte_next = '0;
        bit_next  = 3'd0;
        fill_next = '0;
      end
      default: begin
        byte_next = byte_cursor + CW'(adv_end[6:3]);
        bit_next  = adv_end[2:0];
        if (fill_upd && (fill_cand > {1'b0, fill_length})) begin
          fill_next = fill_cand[CW-1:0];
        end
      end
    endcase
  end

  // Byte store
  logic [CW-1:0] addr_sum;
  logic [7:0]    rd_byte, keep_mask, wr_byte;
  logic [8:0]    keep_full;
  assign addr_sum  = byte_cursor + CW'(cnt);
  assign keep_full = (9'd1 << bit_cursor) - 9'd1;
  assign keep_mask = keep_full[7:0];
  // Merge the low bits of the first byte, write the rest whole
  assign wr_byte   = (cnt == 3'd0) ? (word_q[cnt] | (rd_byte & keep_mask)) : word_q[cnt];

  bfp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr),
    .wr_addr (addr_sum[AW-1:0]),
    .wr_data (wr_byte),
    .rd_en   (cmd.rd | cmd.rd_old),
    .rd_addr (addr_sum[AW-1:0]),
    .rd_data (rd_byte)
  );

  // Status to the controller
  always_comb begin
    stat.chk_err   = chk_err;
    stat.span_zero = (chk_span == 4'd0);
    stat.is_write  = is_write;
    stat.is_read   = is_read;
    stat.bit_nz    = (bit_cursor != 3'd0);
    stat.cnt_last  = (cnt == (nbytes_q - 3'd1));
  end

  // Latch item and decode
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q   <= command;
      value_q <= value;
      width_q <= width;
      limit_q <= limit;
    end
    if (cmd.decode) begin
      fld_w  <= dec_w;
      fld_tw <= dec_tw;
    end
  end

  // Pending result: set at check, refined at extract
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      res_data   <= '0;
      res_status <= chk_err ? (is_write ? bfp_pkg::ST_FULL : bfp_pkg::ST_PAST_FILL)
                            : bfp_pkg::ST_OK;
      res_used   <= (is_write && !chk_err) ? fld_w : 6'd0;
      adv_bits   <= (is_write && !chk_err) ? fld_tw : 6'd0;
      fill_upd   <= is_write && !chk_err && (chk_span != 4'd0);
      nbytes_q   <= chk_nbytes;
      word_q     <= word_next;
    end else if (cmd.extract) begin
      if (is_rvar) begin
        if (var_err) begin
          res_data   <= '0;
          res_used   <= 6'd0;
          res_status <= bfp_pkg::ST_PAST_FILL;
          adv_bits   <= 6'd0;
        end else begin
          res_data   <= win_sh[36:5] & low_mask(6'(var_len));
          res_used   <= 6'(var_len);
          res_status <= bfp_pkg::ST_OK;
          adv_bits   <= var_tw;
        end
      end else begin
        res_data   <= win_sh[31:0] & low_mask(fld_w);
        res_used   <= fld_w;
        res_status <= bfp_pkg::ST_OK;
        adv_bits   <= fld_w;
      end
    end
  end

  // Capture read bytes in the cycle after their address
  always_ff @(posedge clk) begin
    if (cap_valid) begin
      window[cap_idx] <= rd_byte;
    end
    cap_idx <= cnt;
  end

  // Byte counter, capture flag and cursors
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= 3'd0;
      cap_valid   <= 1'b0;
      byte_cursor <= '0;
      bit_cursor  <= 3'd0;
      fill_length <= '0;
    end else begin
      cap_valid <= cmd.rd;
      if (cmd.check) begin
        cnt <= 3'd0;
      end else if (cmd.wr || cmd.rd) begin
        cnt <= cnt + 3'd1;
      end
      if (cmd.commit) begin
        byte_cursor <= byte_next;
        bit_cursor  <= bit_next;
        fill_length <= fill_next;
      end
    end
  end

  // Result item register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      read_data     <= res_data;
      width_used    <= res_used;
      status        <= res_status;
      byte_position <= byte_next;
      bit_position  <= bit_next;
      filled_bytes  <= fill_next;
    end
  end

endmodule

[hdl/bit_field_packer_unpacker_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit field packer/unpacker core
// Byte store with a bit cursor that packs and unpacks fields LSB first.
// ----------------------------------------------------------------------------
// Each item on the input stream is one command and gives exactly one result
// item. Items are handled one at a time through a byte-wide store with one
// read and one write port, one store byte per cycle. A cursor, zero-width or
// out-of-range command is only decoded, checked and committed; a write also
// writes each byte it touches (up to 6), after a read of the first byte when
// it starts inside a byte; a read also fetches bytes, then drains and
// extracts: the bytes the field touches for plain reads (up to 5), and the
// bytes a 36-bit field would touch for self-sized reads (5 or 6), so a
// self-sized read whose value runs past the fill also fetches them all. A
// new item is taken while the previous result still waits on the output;
// the next result then holds in its finish state until the output is free.
// Store contents are undefined until written; there is no clearing pass
// after reset, and clear resets the cursors and fill length, not the store.
// ----------------------------------------------------------------------------
module bit_field_packer_unpacker_core #(
  parameter int STORE_BYTES = 1024,
  localparam int CW = $clog2(STORE_BYTES + 1),
  localparam int OUT_BITS = 43 + 2 * CW,
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // command[3:0], value[35:4], width[41:36], limit[73:42], zero pad
  input  logic [bfp_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // read_data[31:0], width_used[37:32], status[39:38], byte_position,
  // bit_position (3), filled_bytes, zero pad
  output logic [OUT_W-1:0]                  m_tdata
);

  bfp_pkg::bfp_cmd_t  cmd;
  bfp_pkg::bfp_stat_t stat;

  logic [31:0]   read_data;
  logic [5:0]    width_used;
  logic [1:0]    status;
  logic [CW-1:0] byte_position;
  logic [2:0]    bit_position;
  logic [CW-1:0] filled_bytes;

  bfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfp_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .command       (s_tdata[3:0]),
    .value         (s_tdata[35:4]),
    .width         (s_tdata[41:36]),
    .limit         (s_tdata[73:42]),
    .cmd           (cmd),
    .stat          (stat),
    .read_data     (read_data),
    .width_used    (width_used),
    .status        (status),
    .byte_position (byte_position),
    .bit_position  (bit_position),
    .filled_bytes  (filled_bytes)
  );

  // Pack the result item, first field lowest
  assign m_tdata = OUT_W'({filled_bytes, bit_position, byte_position,
                           status, width_used, read_data});

endmodule

[dv/tb_bit_field_packer_unpacker_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the bit field packer/unpacker core
// Drives command items into the stream input and checks every result item
// against a cycle-free model of the byte store and its cursors. Directed
// corner cases come first, then a store fill, backpressure, a drain pause and
// random write/read-back sequences mixed with noise.
// ----------------------------------------------------------------------------
module tb_bit_field_packer_unpacker_core;

  localparam int STORE     = 1024;
  localparam int CW        = $clog2(STORE + 1);
  localparam int OUT_W     = ((43 + 2 * CW + 7) / 8) * 8;
  localparam int N_ITEMS   = 1950;
  localparam int TAIL_CYC  = 40;
  localparam logic [3:0] CMD_UNUSED = 4'd15;

  typedef struct {
    logic [3:0]  command;
    logic [31:0] value;
    logic [5:0]  width;
    logic [31:0] limit;
  } packer_item_t;

  typedef struct {
    logic [31:0]   read_data;
    logic [5:0]    width_used;
    logic [1:0]    status;
    logic [CW-1:0] byte_position;
    logic [2:0]    bit_position;
    logic [CW-1:0] filled_bytes;
  } packer_result_t;

  // One written field, kept to replay it as a read
  typedef struct {
    logic [3:0]  command;
    logic [5:0]  width;
    logic [31:0] limit;
  } field_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // command[3:0], value[35:4], width[41:36], limit[73:42], zero pad
  logic [bfp_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // read_data[31:0], width_used[37:32], status[39:38], byte_position,
  // bit_position (3), filled_bytes, zero pad
  logic [OUT_W-1:0] m_tdata;

  // Model state of the store and cursors
  logic [7:0]  model_mem [0:STORE-1];
  int unsigned model_byte;
  int unsigned model_bit;
  int unsigned model_fill;

  packer_result_t pending_results [$];
  field_rec_t     written_fields [$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int reads_ok = 0;
  int past_fill_hits = 0;
  int full_hits = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int stall_left = 0;
  int hold_left = 0;

  bit_field_packer_unpacker_core #(
    .STORE_BYTES(STORE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model of the packer
  // --------------------------------------------------------------------------
  function automatic int unsigned width_for_limit(logic [31:0] lim);
    for (int i = 1; i < 32; i++) begin
      if (((64'd1 << i) - 64'd1) >= {32'd0, lim}) return i;
    end
    return 0;
  endfunction

  function automatic int unsigned sat_width(int unsigned w);
    return (w > bfp_pkg::MAX_FIELD_BITS) ? bfp_pkg::MAX_FIELD_BITS : w;
  endfunction

  function automatic int unsigned span_bytes(int unsigned nbits);
    if (nbits == 0) return 0;
    return (model_bit + nbits + 7) >> 3;
  endfunction

  function automatic logic [31:0] peek_field(int unsigned at_byte, int unsigned at_bit,
                                             int unsigned w);
    logic [63:0] acc;
    int unsigned n;
    acc = '0;
    n = (at_bit + w + 7) >> 3;
    if (w == 0) return '0;
    for (int k = 0; k < n && k < 5; k++) begin
      if (at_byte + k < STORE) acc |= {56'd0, model_mem[at_byte + k]} << (8 * k);
    end
    acc = (acc >> at_bit) & ((64'd1 << w) - 64'd1);
    return acc[31:0];
  endfunction

  function automatic void advance_cursor(int unsigned nbits);
    int unsigned stop;
    stop = model_bit + nbits;
    model_byte += stop >> 3;
    model_bit = stop & 7;
  endfunction

  // Store a field at the cursor, keeping the low bits of the first byte
  function automatic void put_field(logic [31:0] val, int unsigned w);
    logic [63:0] v;
    logic [63:0] word;
    logic [7:0]  b;
    int unsigned n;
    v = {32'd0, val};
    if (w == 0) return;
    if (v > ((64'd1 << w) - 64'd1)) v = (64'd1 << w) - 64'd1;
    n = span_bytes(w);
    word = v << model_bit;
    for (int k = 0; k < n && k < 5; k++) begin
      if (model_byte + k >= STORE) break;
      b = word[8 * k +: 8];
      if (k == 0) b |= model_mem[model_byte] & ((8'd1 << model_bit) - 8'd1);
      model_mem[model_byte + k] = b;
    end
    if (model_byte + n > model_fill) model_fill = model_byte + n;
    advance_cursor(w);
  endfunction

  function automatic packer_result_t field_op_result(packer_item_t it);
    packer_result_t r;
    int unsigned w;
    r.read_data  = '0;
    r.width_used = '0;
    r.status     = bfp_pkg::ST_OK;
    case (it.command)
      bfp_pkg::CMD_WRITE, bfp_pkg::CMD_WRITE_FOR: begin
        w = sat_width(it.command == bfp_pkg::CMD_WRITE ? it.width
                                                       : width_for_limit(it.limit));
        if (model_byte + span_bytes(w) > STORE) begin
          r.status = bfp_pkg::ST_FULL;
        end else begin
          put_field(it.value, w);
          r.width_used = 6'(w);
        end
      end
      bfp_pkg::CMD_READ, bfp_pkg::CMD_READ_FOR: begin
        w = sat_width(it.command == bfp_pkg::CMD_READ ? it.width
                                                      : width_for_limit(it.limit));
        if (model_byte + span_bytes(w) > model_fill) begin
          r.status = bfp_pkg::ST_PAST_FILL;
        end else begin
          r.read_data = peek_field(model_byte, model_bit, w);
          advance_cursor(w);
          r.width_used = 6'(w);
        end
      end
      bfp_pkg::CMD_WRITE_VAR: begin
        w = sat_width(width_for_limit(it.value));
        if (model_byte + span_bytes(bfp_pkg::LEN_BITS + w) > STORE) begin
          r.status = bfp_pkg::ST_FULL;
        end else begin
          put_field(w, bfp_pkg::LEN_BITS);
          put_field(it.value, w);
          r.width_used = 6'(w);
        end
      end
      bfp_pkg::CMD_READ_VAR: begin
        if (model_byte + span_bytes(bfp_pkg::LEN_BITS) > model_fill) begin
          r.status = bfp_pkg::ST_PAST_FILL;
        end else begin
          w = sat_width(peek_field(model_byte, model_bit, bfp_pkg::LEN_BITS));
          if (model_byte + span_bytes(bfp_pkg::LEN_BITS + w) > model_fill) begin
            r.status = bfp_pkg::ST_PAST_FILL;
          end else begin
            advance_cursor(bfp_pkg::LEN_BITS);
            r.read_data = peek_field(model_byte, model_bit, w);
            advance_cursor(w);
            r.width_used = 6'(w);
          end
        end
      end
      bfp_pkg::CMD_ALIGN: begin
        if (model_bit != 0) begin
          model_byte += 1;
          model_bit = 0;
        end
      end
      bfp_pkg::CMD_REWIND: begin
        model_byte = 0;
        model_bit = 0;
      end
      bfp_pkg::CMD_TO_END: begin
        model_byte = model_fill;
        model_bit = 0;
      end
      bfp_pkg::CMD_CLEAR: begin
        model_fill = 0;
        model_byte = 0;
        model_bit = 0;
      end
      default: begin
      end
    endcase
    r.byte_position = CW'(model_byte);
    r.bit_position  = 3'(model_bit);
    r.filled_bytes  = CW'(model_fill);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: stall per item, long hold on request, check each item
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    packer_result_t got;
    packer_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.read_data     = m_tdata[31:0];
      got.width_used    = m_tdata[37:32];
      got.status        = m_tdata[39:38];
      got.byte_position = m_tdata[40 +: CW];
      got.bit_position  = m_tdata[40 + CW +: 3];
      got.filled_bytes  = m_tdata[43 + CW +: CW];
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: data %h", m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.read_data !== want.read_data) begin
          $error("read_data expected %h got %h", want.read_data, got.read_data);
          errors++;
        end
        if (got.width_used !== want.width_used) begin
          $error("width_used expected %0d got %0d", want.width_used, got.width_used);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, got.status);
          errors++;
        end
        if (got.byte_position !== want.byte_position) begin
          $error("byte_position expected %0d got %0d", want.byte_position,
                 got.byte_position);
          errors++;
        end
        if (got.bit_position !== want.bit_position) begin
          $error("bit_position expected %0d got %0d", want.bit_position, got.bit_position);
          errors++;
        end
        if (got.filled_bytes !== want.filled_bytes) begin
          $error("filled_bytes expected %0d got %0d", want.filled_bytes, got.filled_bytes);
          errors++;
        end
      end
      stall_left = rx_idle ? $urandom_range(0, 11) : 0;
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [3:0] cmd, input logic [31:0] value,
                           input logic [5:0] width, input logic [31:0] limit);
    packer_item_t   it;
    packer_result_t r;
    int gap;
    it.command = cmd;
    it.value   = value;
    it.width   = width;
    it.limit   = limit;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, it.limit, it.width, it.value, it.command};
    do @(posedge clk); while (!s_tready);
    r = field_op_result(it);
    pending_results.push_back(r);
    items_sent++;
    if (r.status == bfp_pkg::ST_PAST_FILL) past_fill_hits++;
    else if (r.status == bfp_pkg::ST_FULL) full_hits++;
    else if (cmd inside {bfp_pkg::CMD_READ, bfp_pkg::CMD_READ_FOR, bfp_pkg::CMD_READ_VAR})
      reads_ok++;
  endtask

  task automatic send_cursor(input logic [3:0] cmd);
    send_item(cmd, $urandom, 6'($urandom_range(0, 63)), $urandom);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom;
      3: return $urandom_range(0, 255);
      4: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // Drop the offer, then wait until every expected result has come
  task automatic wait_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYC) @(negedge clk);
  endtask

  // Write a run of fields from the start, rewind, then read them back
  task automatic run_sequence(input int n_ops);
    field_rec_t fr;
    logic [31:0] v;
    if ($urandom_range(0, 1)) send_cursor(bfp_pkg::CMD_CLEAR);
    else send_cursor(bfp_pkg::CMD_REWIND);
    written_fields.delete();
    repeat (n_ops) begin
      fr.width = 6'($urandom_range(0, 32));
      fr.limit = rand_word();
      v = rand_word();
      case ($urandom_range(0, 9))
        0, 1, 2: fr.command = bfp_pkg::CMD_WRITE;
        3: begin
          fr.command = bfp_pkg::CMD_WRITE;
          fr.width = 6'($urandom_range(33, 63));
        end
        4, 5: fr.command = bfp_pkg::CMD_WRITE_FOR;
        6, 7: fr.command = bfp_pkg::CMD_WRITE_VAR;
        default: fr.command = bfp_pkg::CMD_ALIGN;
      endcase
      // mostly values that fit, sometimes clamped
      if (fr.command == bfp_pkg::CMD_WRITE && fr.width < 32 && $urandom_range(0, 3) != 0)
        v &= (32'd1 << fr.width) - 32'd1;
      send_item(fr.command, v, fr.width, fr.limit);
      written_fields.push_back(fr);
    end
    send_cursor(bfp_pkg::CMD_REWIND);
    foreach (written_fields[i]) begin
      fr = written_fields[i];
      case (fr.command)
        bfp_pkg::CMD_WRITE:     fr.command = bfp_pkg::CMD_READ;
        bfp_pkg::CMD_WRITE_FOR: fr.command = bfp_pkg::CMD_READ_FOR;
        bfp_pkg::CMD_WRITE_VAR: fr.command = bfp_pkg::CMD_READ_VAR;
        default: begin
        end
      endcase
      // now and then break the read-back
      if ($urandom_range(0, 11) == 0) fr.width = 6'($urandom_range(0, 63));
      if ($urandom_range(0, 11) == 0) fr.limit = rand_word();
      send_item(fr.command, $urandom, fr.width, fr.limit);
    end
    case ($urandom_range(0, 3))
      0: begin
        send_cursor(bfp_pkg::CMD_TO_END);
        send_item(bfp_pkg::CMD_WRITE_VAR, rand_word(), 6'($urandom_range(0, 63)),
                  $urandom);
      end
      1: send_item(bfp_pkg::CMD_READ, $urandom, 6'($urandom_range(1, 40)), $urandom);
      default: begin
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_corner_cases();
    // empty store: reads run past the fill
    send_item(bfp_pkg::CMD_READ, '0, 6'd8, '0);
    send_cursor(bfp_pkg::CMD_READ_VAR);
    // widths and clamping at the extremes, one field spanning five bytes
    send_item(bfp_pkg::CMD_WRITE, 32'hFF, 6'd0, '0);
    send_item(bfp_pkg::CMD_WRITE, 32'hFFFF_FFFF, 6'd32, '0);
    send_item(bfp_pkg::CMD_WRITE, 32'd3, 6'd1, '0);
    send_item(bfp_pkg::CMD_WRITE, 32'h1234_5678, 6'd40, '0);
    send_item(bfp_pkg::CMD_WRITE_FOR, 32'd5, 6'd0, 32'd0);
    send_item(bfp_pkg::CMD_WRITE_FOR, 32'h5A5A_5A5A, 6'd0, 32'h7FFF_FFFF);
    send_item(bfp_pkg::CMD_WRITE_FOR, 32'd1, 6'd0, 32'hFFFF_FFFF);
    send_item(bfp_pkg::CMD_WRITE_VAR, 32'd0, 6'd0, '0);
    send_item(bfp_pkg::CMD_WRITE_VAR, 32'h7FFF_FFFF, 6'd0, '0);
    send_item(bfp_pkg::CMD_WRITE_VAR, 32'hFFFF_FFFF, 6'd63, '0);
    // align twice, with the cursor on a byte boundary
    send_cursor(bfp_pkg::CMD_ALIGN);
    send_cursor(bfp_pkg::CMD_ALIGN);
    send_cursor(bfp_pkg::CMD_REWIND);
    send_item(bfp_pkg::CMD_READ, '0, 6'd32, '0);
    send_item(bfp_pkg::CMD_READ, '0, 6'd63, '0);
    send_item(bfp_pkg::CMD_READ, '0, 6'd1, '0);
    send_item(bfp_pkg::CMD_READ_FOR, '0, 6'd0, 32'd0);
    send_item(bfp_pkg::CMD_READ_FOR, '0, 6'd0, 32'h7FFF_FFFF);
    send_cursor(bfp_pkg::CMD_READ_VAR);
    send_cursor(bfp_pkg::CMD_READ_VAR);
    send_cursor(bfp_pkg::CMD_TO_END);
    send_item(bfp_pkg::CMD_READ, '0, 6'd1, '0);
    send_cursor(CMD_UNUSED);
    send_cursor(bfp_pkg::CMD_CLEAR);
    send_item(bfp_pkg::CMD_READ, '0, 6'd0, '0);
  endtask

  task automatic test_store_full();
    logic [3:0] cmd;
    send_cursor(bfp_pkg::CMD_CLEAR);
    send_item(bfp_pkg::CMD_WRITE, $urandom, 6'd3, '0);
    while (model_byte < STORE - 4)
      send_item(bfp_pkg::CMD_WRITE, $urandom, 6'($urandom_range(17, 32)), '0);
    // last few bits: some fit, the rest report a full store
    repeat (16) begin
      case ($urandom_range(0, 2))
        0: cmd = bfp_pkg::CMD_WRITE;
        1: cmd = bfp_pkg::CMD_WRITE_FOR;
        default: cmd = bfp_pkg::CMD_WRITE_VAR;
      endcase
      send_item(cmd, rand_word(), 6'($urandom_range(0, 40)), rand_word());
    end
    send_cursor(bfp_pkg::CMD_TO_END);
    send_item(bfp_pkg::CMD_READ, '0, 6'd8, '0);
    send_cursor(bfp_pkg::CMD_REWIND);
    repeat (24) send_item(bfp_pkg::CMD_READ, '0, 6'd32, '0);
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    hold_left = 300;
    run_sequence(12);
    tx_idle = 1'b1;
  endtask

  task automatic test_drain_pause();
    run_sequence(6);
    wait_drain();
    run_sequence(6);
  endtask

  task automatic test_random_mix();
    while (items_sent < N_ITEMS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 8))
          send_item(4'($urandom_range(0, 15)), rand_word(), 6'($urandom_range(0, 63)),
                    rand_word());
      end else begin
        run_sequence($urandom_range(1, 12));
      end
    end
  endtask

  initial begin
    model_byte = 0;
    model_bit  = 0;
    model_fill = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_corner_cases();
    test_store_full();
    test_backpressure();
    test_drain_pause();
    test_random_mix();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_drain();
    $display("ran %0d command items, checked %0d result items", items_sent, results_seen);
    $display("reads ok %0d, past fill %0d, store full %0d", reads_ok, past_fill_hits,
             full_hits);
    if (errors == 0) begin
      $display("tb_bit_field_packer_unpacker_core: clean");
    end else begin
      $display("tb_bit_field_packer_unpacker_core: errors");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #10_000_000;
    $display("tb_bit_field_packer_unpacker_core: errors");
    $finish;
  end

endmodule
